/* rtl/dnc_pkg.sv */
// Shared widths, constants and types for the day number to civil date converter.
package dnc_pkg;

	// Number of binary fraction bits in day_fraction.
	localparam int FRAC_BITS = 32;
	localparam int NSTAGES   = 7;

	// Port field widths.
	localparam int MJD_W   = 23;
	localparam int FRAC_W  = 32;
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int MILLI_W = 16;

	// Internal value widths.
	localparam int L0_W   = 23;
	localparam int N_W    = 8;
	localparam int L1_W   = 16;
	localparam int I_W    = 7;
	localparam int L2_W   = 16;
	localparam int J_W    = 6;
	localparam int MS_W   = 27;
	localparam int MINS_W = 11;

	localparam logic signed [MJD_W-1:0] MJD_MIN = -23'sd678575;
	localparam logic signed [MJD_W-1:0] MJD_MAX = 23'sd2973483;
	// Julian day offset plus the first constant of the date algorithm.
	localparam logic signed [MJD_W:0] JDN_BIAS = 24'sd2468570;

	localparam logic [MS_W-1:0]    MS_PER_DAY = 27'd86400000;
	localparam logic [MILLI_W-1:0] MS_PER_MIN = 16'd60000;
	localparam logic [FRAC_W-1:0]  FRAC_MASK  = (FRAC_BITS >= FRAC_W) ? '1 :
		FRAC_W'((64'd1 << FRAC_BITS) - 64'd1);

	// Rounded-up reciprocals. Each shift is chosen so that dividend times divisor
	// stays below two to the shift, which makes the truncated product exact.
	localparam int N_SHIFT   = 43;
	localparam int N_RECIP_W = 26;
	localparam logic [N_RECIP_W-1:0] N_RECIP =
		N_RECIP_W'(((64'd1 << N_SHIFT) + 64'd146096) / 64'd146097);

	localparam int I_SHIFT   = 49;
	localparam int I_RECIP_W = 29;
	localparam logic [I_RECIP_W-1:0] I_RECIP =
		I_RECIP_W'(((64'd1 << I_SHIFT) + 64'd1461000) / 64'd1461001);

	localparam int J_SHIFT   = 35;
	localparam int J_RECIP_W = 24;
	localparam logic [J_RECIP_W-1:0] J_RECIP =
		J_RECIP_W'(((64'd1 << J_SHIFT) + 64'd2446) / 64'd2447);

	// Scaled 2447/80, so floor(2447 * j / 80) needs one multiply.
	localparam int K_SHIFT   = 16;
	localparam int K_RECIP_W = 21;
	localparam logic [K_RECIP_W-1:0] K_RECIP =
		K_RECIP_W'((64'd2447 * (64'd1 << K_SHIFT) + 64'd79) / 64'd80);

	localparam int MN_SHIFT   = 43;
	localparam int MN_RECIP_W = 28;
	localparam logic [MN_RECIP_W-1:0] MN_RECIP =
		MN_RECIP_W'(((64'd1 << MN_SHIFT) + 64'd59999) / 64'd60000);

	localparam int HR_SHIFT   = 17;
	localparam int HR_RECIP_W = 12;
	localparam logic [HR_RECIP_W-1:0] HR_RECIP =
		HR_RECIP_W'(((64'd1 << HR_SHIFT) + 64'd59) / 64'd60);

	typedef struct packed {
		logic [NSTAGES-1:0] adv;
	} pipe_ctrl_t;

	typedef struct packed {
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [MILLI_W-1:0] second_milli;
	} tod_t;

endpackage

/* rtl/dnc_stamp_if.sv */
// Input channel: day number and day fraction with valid/ready.
interface dnc_stamp_if import dnc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [MJD_W-1:0]  mjd_day;
	logic [FRAC_W-1:0]        day_fraction;

	modport source(output valid, output mjd_day, output day_fraction, input ready);
	modport sink(input valid, input mjd_day, input day_fraction, output ready);
endinterface

/* rtl/dnc_civil_if.sv */
// Output channel: civil date and time of day with valid/ready.
interface dnc_civil_if import dnc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [YEAR_W-1:0]   year;
	logic [MONTH_W-1:0]  month;
	logic [DAY_W-1:0]    day_of_month;
	logic [HOUR_W-1:0]   hour;
	logic [MIN_W-1:0]    minute;
	logic [MILLI_W-1:0]  second_milli;

	modport source(output valid, output year, output month, output day_of_month,
		output hour, output minute, output second_milli, input ready);
	modport sink(input valid, input year, input month, input day_of_month,
		input hour, input minute, input second_milli, output ready);
endinterface

/* rtl/dnc_date_pipe.sv */
// Seven-stage datapath from day number to Gregorian year, month and day.
module dnc_date_pipe import dnc_pkg::*; (
	input  logic                    clk,
	input  pipe_ctrl_t              ctrl,
	input  logic signed [MJD_W-1:0] mjd_day,
	output logic [YEAR_W-1:0]       year,
	output logic [MONTH_W-1:0]      month,
	output logic [DAY_W-1:0]        day_of_month
);

	localparam int NX_W  = L0_W + 2;
	localparam int NP_W  = NX_W + N_RECIP_W;
	localparam int IX_W  = 28;
	localparam int IP_W  = IX_W + I_RECIP_W;
	localparam int JX_W  = 23;
	localparam int JP_W  = JX_W + J_RECIP_W;
	localparam int KP_W  = J_W + K_RECIP_W;
	localparam int KQ_W  = 11;

	// Stage 1: clamp and bias.
	logic signed [MJD_W-1:0] mjd_c;
	logic signed [MJD_W:0]   l0_sum;
	logic [L0_W-1:0]         l0_s1;

	always_comb begin
		priority if (mjd_day < MJD_MIN) begin
			mjd_c = MJD_MIN;
		end else if (mjd_day > MJD_MAX) begin
			mjd_c = MJD_MAX;
		end else begin
			mjd_c = mjd_day;
		end
		l0_sum = (MJD_W+1)'(mjd_c) + JDN_BIAS;
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv[0]) begin
			l0_s1 <= l0_sum[L0_W-1:0];
		end
	end

	// Stage 2: 400-year cycle count.
	logic [NX_W-1:0] nx;
	logic [NP_W-1:0] nprod;
	logic [N_W-1:0]  n_s2;
	logic [L0_W-1:0] l0_s2;

	assign nx    = {l0_s1, 2'b00};
	assign nprod = NP_W'(nx) * NP_W'(N_RECIP);

	always_ff @(posedge clk) begin
		if (ctrl.adv[1]) begin
			n_s2  <= nprod[N_SHIFT +: N_W];
			l0_s2 <= l0_s1;
		end
	end

	// Stage 3: days within the cycle.
	logic [NX_W-1:0] nq;
	logic [L1_W-1:0] l1_s3;
	logic [N_W-1:0]  n_s3;

	assign nq = NX_W'(n_s2) * NX_W'(146097) + NX_W'(3);

	always_ff @(posedge clk) begin
		if (ctrl.adv[2]) begin
			l1_s3 <= L1_W'(l0_s2 - nq[NX_W-1:2]);
			n_s3  <= n_s2;
		end
	end

	// Stage 4: year within the cycle.
	logic [IX_W-1:0] ix;
	logic [IP_W-1:0] iprod;
	logic [I_W-1:0]  i_s4;
	logic [L1_W-1:0] l1_s4;
	logic [N_W-1:0]  n_s4;

	assign ix    = (IX_W'(l1_s3) + IX_W'(1)) * IX_W'(4000);
	assign iprod = IP_W'(ix) * IP_W'(I_RECIP);

	always_ff @(posedge clk) begin
		if (ctrl.adv[3]) begin
			i_s4  <= iprod[I_SHIFT +: I_W];
			l1_s4 <= l1_s3;
			n_s4  <= n_s3;
		end
	end

	// Stage 5: day of the March-based year.
	logic [17:0]     iq;
	logic [L2_W:0]   l2_c;
	logic [L2_W-1:0] l2_s5;
	logic [I_W-1:0]  i_s5;
	logic [N_W-1:0]  n_s5;

	assign iq   = 18'(i_s4) * 18'd1461;
	assign l2_c = (L2_W+1)'(l1_s4) - (L2_W+1)'(iq[17:2]) + (L2_W+1)'(31);

	always_ff @(posedge clk) begin
		if (ctrl.adv[4]) begin
			l2_s5 <= l2_c[L2_W-1:0];
			i_s5  <= i_s4;
			n_s5  <= n_s4;
		end
	end

	// Stage 6: March-based month.
	logic [JX_W-1:0] jx;
	logic [JP_W-1:0] jprod;
	logic [J_W-1:0]  j_s6;
	logic [L2_W-1:0] l2_s6;
	logic [I_W-1:0]  i_s6;
	logic [N_W-1:0]  n_s6;

	assign jx    = JX_W'(l2_s5) * JX_W'(80);
	assign jprod = JP_W'(jx) * JP_W'(J_RECIP);

	always_ff @(posedge clk) begin
		if (ctrl.adv[5]) begin
			j_s6  <= jprod[J_SHIFT +: J_W];
			l2_s6 <= l2_s5;
			i_s6  <= i_s5;
			n_s6  <= n_s5;
		end
	end

	// Stage 7: day of month, and the shift from March-based to January-based year.
	logic [KP_W-1:0]    kprod;
	logic [KQ_W-1:0]    kq;
	logic               carry_c;
	logic [YEAR_W-1:0]  year_s7;
	logic [MONTH_W-1:0] month_s7;
	logic [DAY_W-1:0]   day_s7;

	assign kprod   = KP_W'(j_s6) * KP_W'(K_RECIP);
	assign kq      = kprod[K_SHIFT +: KQ_W];
	// The month index never reaches 22, so dividing it by 11 is one compare.
	assign carry_c = (j_s6 >= J_W'(11));

	always_ff @(posedge clk) begin
		if (ctrl.adv[6]) begin
			day_s7   <= DAY_W'(l2_s6 - L2_W'(kq));
			month_s7 <= MONTH_W'(j_s6 + J_W'(2) - (carry_c ? J_W'(12) : J_W'(0)));
			year_s7  <= (YEAR_W'(n_s6) - YEAR_W'(49)) * YEAR_W'(100)
				+ YEAR_W'(i_s6) + YEAR_W'(carry_c);
		end
	end

	assign year         = year_s7;
	assign month        = month_s7;
	assign day_of_month = day_s7;

endmodule

/* rtl/dnc_time_pipe.sv */
// Seven-stage datapath from day fraction to hour, minute and milliseconds.
module dnc_time_pipe import dnc_pkg::*; (
	input  logic              clk,
	input  pipe_ctrl_t        ctrl,
	input  logic [FRAC_W-1:0] day_fraction,
	output tod_t              tod
);

	localparam int FP_W = FRAC_W + MS_W;
	localparam int MP_W = MS_W + MN_RECIP_W;
	localparam int HP_W = MINS_W + HR_RECIP_W;

	// Stage 1: milliseconds since midnight, truncated.
	logic [FP_W-1:0] fprod;
	logic [MS_W-1:0] ms_s1;

	assign fprod = FP_W'(day_fraction & FRAC_MASK) * FP_W'(MS_PER_DAY);

	always_ff @(posedge clk) begin
		if (ctrl.adv[0]) begin
			ms_s1 <= MS_W'(fprod >> FRAC_BITS);
		end
	end

	// Stage 2: minutes since midnight.
	logic [MP_W-1:0]   mprod;
	logic [MINS_W-1:0] mins_s2;
	logic [MS_W-1:0]   ms_s2;

	assign mprod = MP_W'(ms_s1) * MP_W'(MN_RECIP);

	always_ff @(posedge clk) begin
		if (ctrl.adv[1]) begin
			mins_s2 <= mprod[MN_SHIFT +: MINS_W];
			ms_s2   <= ms_s1;
		end
	end

	// Stage 3: hour and the milliseconds left in the minute.
	logic [HP_W-1:0]    hprod;
	logic [MS_W-1:0]    ms_rem;
	logic [HOUR_W-1:0]  hour_s3;
	logic [MINS_W-1:0]  mins_s3;
	logic [MILLI_W-1:0] milli_s3;

	assign hprod  = HP_W'(mins_s2) * HP_W'(HR_RECIP);
	assign ms_rem = ms_s2 - MS_W'(mins_s2) * MS_W'(MS_PER_MIN);

	always_ff @(posedge clk) begin
		if (ctrl.adv[2]) begin
			hour_s3  <= hprod[HR_SHIFT +: HOUR_W];
			mins_s3  <= mins_s2;
			milli_s3 <= ms_rem[MILLI_W-1:0];
		end
	end

	// Stage 4: minute within the hour; later stages only align with the date side.
	logic [MINS_W-1:0] min_rem;
	tod_t              tod_s4;
	tod_t              tod_s5;
	tod_t              tod_s6;
	tod_t              tod_s7;

	assign min_rem = mins_s3 - MINS_W'(hour_s3) * MINS_W'(60);

	always_ff @(posedge clk) begin
		if (ctrl.adv[3]) begin
			tod_s4.hour         <= hour_s3;
			tod_s4.minute       <= min_rem[MIN_W-1:0];
			tod_s4.second_milli <= milli_s3;
		end
		if (ctrl.adv[4]) begin
			tod_s5 <= tod_s4;
		end
		if (ctrl.adv[5]) begin
			tod_s6 <= tod_s5;
		end
		if (ctrl.adv[6]) begin
			tod_s7 <= tod_s6;
		end
	end

	assign tod = tod_s7;

endmodule

/* rtl/day_number_to_civil_date.sv */
// Top level: Modified Julian Day and day fraction to civil date and time of day.
// The pipeline has seven stages between an accepted input beat and its output beat.
// Throughput is one beat per cycle while civil.ready is high.
// A stage holds its beat only while every stage after it is full and stalled.
// Reset clears the stage valid bits only; the datapath registers are not reset.
module day_number_to_civil_date import dnc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	dnc_stamp_if.sink    stamp,
	dnc_civil_if.source  civil
);

	logic [NSTAGES-1:0] v_q;
	pipe_ctrl_t         ctrl;
	tod_t               tod;

	// A stage may load when it is empty or the stage after it is loading.
	always_comb begin
		ctrl.adv[NSTAGES-1] = !v_q[NSTAGES-1] || civil.ready;
		for (int k = NSTAGES - 2; k >= 0; k--) begin
			ctrl.adv[k] = !v_q[k] || ctrl.adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (ctrl.adv[0]) begin
				v_q[0] <= stamp.valid;
			end
			for (int k = 1; k < NSTAGES; k++) begin
				if (ctrl.adv[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	dnc_date_pipe u_date (
		.clk          (clk),
		.ctrl         (ctrl),
		.mjd_day      (stamp.mjd_day),
		.year         (civil.year),
		.month        (civil.month),
		.day_of_month (civil.day_of_month)
	);

	dnc_time_pipe u_time (
		.clk          (clk),
		.ctrl         (ctrl),
		.day_fraction (stamp.day_fraction),
		.tod          (tod)
	);

	assign stamp.ready        = ctrl.adv[0];
	assign civil.valid        = v_q[NSTAGES-1];
	assign civil.hour         = tod.hour;
	assign civil.minute       = tod.minute;
	assign civil.second_milli = tod.second_milli;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		stamp.valid && stamp.ready |=> v_q[0])
		else $error("accepted beat did not enter the first stage");

	a_free_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!civil.valid |-> stamp.ready)
		else $error("input stalled while the output stage is empty");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		civil.valid |-> civil.year >= YEAR_W'(1) && civil.year <= YEAR_W'(9999)
			&& civil.month >= MONTH_W'(1) && civil.month <= MONTH_W'(12)
			&& civil.day_of_month >= DAY_W'(1) && civil.day_of_month <= DAY_W'(31))
		else $error("civil date out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		civil.valid |-> civil.hour <= HOUR_W'(23) && civil.minute <= MIN_W'(59)
			&& civil.second_milli <= MILLI_W'(59999))
		else $error("time of day out of range");

endmodule
